// File: hdl/mblf_pkg.sv
// ============================================================================
// mblf_pkg
// Shared widths, codes and defaults for the mirror-boundary line FIR.
// ============================================================================
package mblf_pkg;

    // Defaults for the top-level parameters
    localparam int LINE_MAX_DEF = 1024;
    localparam int MAX_TAPS_DEF = 16;

    // Field widths
    localparam int POS_W      = 10;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int LEN_CFG_W  = 11;
    localparam int TAPS_CFG_W = 5;
    localparam int OFF_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Coefficient packing: four taps per 64-bit word, sixteen taps total
    localparam int COEF_WORDS = 4;
    localparam int NUM_COEFS  = 16;

    // Q1.14 rounding
    localparam int ROUND_SHIFT = 14;
    localparam int ROUND_HALF  = 8192;
    localparam int SAMPLE_MAX  = 32767;
    localparam int SAMPLE_MIN  = -32768;

    // Commands
    localparam logic CMD_STORE   = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_WORD_0   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_WORD_1   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_WORD_2   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_WORD_3   = 3'd6;

    // Register reset values
    localparam logic [LEN_CFG_W-1:0]  LINE_LENGTH_RST = 11'd1024;
    localparam logic [TAPS_CFG_W-1:0] TAP_COUNT_RST   = 5'd1;

endpackage

// File: hdl/mblf_ram.sv
// ============================================================================
// mblf_ram
// Generic RAM: one write port, one read port, registered read data.
// ============================================================================
module mblf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/mblf_fold.sv
// ============================================================================
// mblf_fold
// Bit-serial remainder unit: position mod m and offset mod m in two lanes,
// one dividend bit per cycle.
// ============================================================================
module mblf_fold #(
    parameter int LINE_MAX = mblf_pkg::LINE_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [mblf_pkg::POS_W-1:0]          pos,
    input  logic [mblf_pkg::OFF_W-1:0]          off,
    input  logic [$clog2(LINE_MAX+1):0]         modulus,
    output logic                                done,
    output logic [$clog2(LINE_MAX+1):0]         pos_rem,
    output logic [$clog2(LINE_MAX+1):0]         off_rem
);

    import mblf_pkg::*;

    localparam int M_W   = $clog2(LINE_MAX + 1) + 1;
    localparam int CNT_W = $clog2(POS_W + 1);

    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic             done_reg,  done_next;
    logic [POS_W-1:0] pos_sh_reg, pos_sh_next;
    logic [POS_W-1:0] off_sh_reg, off_sh_next;
    logic [M_W-1:0]   pos_rem_reg, pos_rem_next;
    logic [M_W-1:0]   off_rem_reg, off_rem_next;

    // one restoring step: shift in a bit, subtract m if it fits
    function automatic logic [M_W-1:0] rem_step(input logic [M_W-1:0] rem,
                                                input logic           din,
                                                input logic [M_W-1:0] m);
        logic [M_W:0] cand;
        begin
            cand = {rem, din};
            if (cand >= {1'b0, m})
            begin
                cand = cand - {1'b0, m};
            end
            return cand[M_W-1:0];
        end
    endfunction

    always_comb
    begin
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        pos_sh_next  = pos_sh_reg;
        off_sh_next  = off_sh_reg;
        pos_rem_next = pos_rem_reg;
        off_rem_next = off_rem_reg;
        if (start)
        begin
            cnt_next     = CNT_W'(POS_W);
            pos_sh_next  = pos;
            off_sh_next  = POS_W'(off);
            pos_rem_next = '0;
            off_rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next     = cnt_reg - CNT_W'(1);
            done_next    = (cnt_reg == CNT_W'(1));
            pos_sh_next  = {pos_sh_reg[POS_W-2:0], 1'b0};
            off_sh_next  = {off_sh_reg[POS_W-2:0], 1'b0};
            pos_rem_next = rem_step(pos_rem_reg, pos_sh_reg[POS_W-1], modulus);
            off_rem_next = rem_step(off_rem_reg, off_sh_reg[POS_W-1], modulus);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_sh_reg  <= pos_sh_next;
        off_sh_reg  <= off_sh_next;
        pos_rem_reg <= pos_rem_next;
        off_rem_reg <= off_rem_next;
    end

    assign done    = done_reg;
    assign pos_rem = pos_rem_reg;
    assign off_rem = off_rem_reg;

endmodule

// File: hdl/mirror_boundary_line_fir_unit.sv
// ============================================================================
// mirror_boundary_line_fir_unit
// One-dimensional FIR over a stored image line with half-sample mirror
// extension at both ends; Q1.14 taps, rounded and saturated 16-bit output.
// ============================================================================
//
//   channel   signals                              direction   transaction
//   --------  -----------------------------------  ----------  ----------------
//   in        in_valid/in_ready, command,          sink        store or compute
//             position, sample
//   out       out_valid/out_ready, filtered,       source      one per compute
//             saturated
//   cfg       cfg_valid/cfg_ready, cfg_index,      sink        register write
//             cfg_data
//
// A store transaction writes the line memory at its accept edge; the unit
// stays ready. A compute transaction passes through the bit-serial fold
// (ten remainder steps and a done flag) reducing position and offset modulo
// 2 * length, one line-memory read per tap, the drain of the multiply-add
// pipeline, a step that rounds, saturates and loads the output register,
// and the idle state that takes the next input.
// The output register holds a finished result while out_ready is low; a
// following store is still taken, a following compute stalls only in its
// finish state. Reset initialises control and configuration; the line
// memory is not cleared.
// ============================================================================
module mirror_boundary_line_fir_unit #(
    parameter int LINE_MAX = mblf_pkg::LINE_MAX_DEF,
    parameter int MAX_TAPS = mblf_pkg::MAX_TAPS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input items
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic [mblf_pkg::POS_W-1:0]          position,
    input  logic signed [mblf_pkg::SAMPLE_W-1:0] sample,
    // results
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [mblf_pkg::SAMPLE_W-1:0] filtered,
    output logic                                saturated,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mblf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mblf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import mblf_pkg::*;

    // ------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------
    localparam int AW     = $clog2(LINE_MAX);
    localparam int LEN_W  = $clog2(LINE_MAX + 1);
    localparam int M_W    = LEN_W + 1;              // holds 2 * length
    localparam int LL_W   = (LEN_CFG_W > LEN_W) ? LEN_CFG_W : LEN_W;
    localparam int TC_W   = $clog2(MAX_TAPS + 1);
    localparam int TI_W   = $clog2(MAX_TAPS);
    localparam int TT_W   = (TAPS_CFG_W > TC_W) ? TAPS_CFG_W : TC_W;
    localparam int TS_W   = (TI_W > 5) ? TI_W : 5;  // room to compare with 16
    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);
    localparam int RS_W   = ACC_W + 1 - ROUND_SHIFT;

    localparam logic signed [RS_W-1:0] SAT_HI = RS_W'(SAMPLE_MAX);
    localparam logic signed [RS_W-1:0] SAT_LO = RS_W'(SAMPLE_MIN);

    // ------------------------------------------------------------------
    // Sequencer states
    // ------------------------------------------------------------------
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FOLD   = 3'd1;
    localparam logic [2:0] S_TAPS   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [LEN_CFG_W-1:0]                     line_length_reg;
    logic [TAPS_CFG_W-1:0]                    tap_count_reg;
    logic [OFF_W-1:0]                         center_offset_reg;
    logic [COEF_WORDS-1:0][CFG_DATA_W-1:0]    coef_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg   <= LINE_LENGTH_RST;
            tap_count_reg     <= TAP_COUNT_RST;
            center_offset_reg <= '0;
            coef_reg          <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LINE_LENGTH:   line_length_reg   <= cfg_data[LEN_CFG_W-1:0];
                CFG_TAP_COUNT:     tap_count_reg     <= cfg_data[TAPS_CFG_W-1:0];
                CFG_CENTER_OFFSET: center_offset_reg <= cfg_data[OFF_W-1:0];
                CFG_COEF_WORD_0:   coef_reg[0]       <= cfg_data;
                CFG_COEF_WORD_1:   coef_reg[1]       <= cfg_data;
                CFG_COEF_WORD_2:   coef_reg[2]       <= cfg_data;
                CFG_COEF_WORD_3:   coef_reg[3]       <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Effective length (1..LINE_MAX) and tap count (0..MAX_TAPS)
    logic [LL_W-1:0]  ll_ext;
    logic [LEN_W-1:0] len_eff;
    logic [M_W-1:0]   modulus;
    logic [TT_W-1:0]  tc_ext;
    logic [TC_W-1:0]  taps_eff;

    always_comb
    begin
        ll_ext = LL_W'(line_length_reg);
        if (ll_ext == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (ll_ext > LL_W'(LINE_MAX))
        begin
            len_eff = LEN_W'(LINE_MAX);
        end
        else
        begin
            len_eff = ll_ext[LEN_W-1:0];
        end

        tc_ext = TT_W'(tap_count_reg);
        if (tc_ext > TT_W'(MAX_TAPS))
        begin
            taps_eff = TC_W'(MAX_TAPS);
        end
        else
        begin
            taps_eff = tc_ext[TC_W-1:0];
        end
    end

    assign modulus = {len_eff, 1'b0};

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic [2:0]       state_reg,   state_next;
    logic [M_W-1:0]   r_reg,       r_next;       // folded tap index, 0..2L-1
    logic [TC_W-1:0]  tap_cnt_reg, tap_cnt_next;
    logic             s1_vld_reg;                // RAM data valid
    logic             s2_vld_reg;                // product valid
    logic             out_valid_reg, out_valid_next;

    logic in_fire;
    logic is_compute;
    logic fold_done;
    logic [M_W-1:0] pos_rem;
    logic [M_W-1:0] off_rem;

    assign in_ready   = (state_reg == S_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign is_compute = (command == CMD_COMPUTE);

    // ------------------------------------------------------------------
    // Fold unit: position mod 2L and offset mod 2L
    // ------------------------------------------------------------------
    mblf_fold #(
        .LINE_MAX (LINE_MAX)
    ) u_fold (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (in_fire && is_compute),
        .pos     (position),
        .off     (center_offset_reg),
        .modulus (modulus),
        .done    (fold_done),
        .pos_rem (pos_rem),
        .off_rem (off_rem)
    );

    // First tap index: (pos - off) mod 2L from the two remainders
    logic [M_W:0]   fold_diff;
    logic [M_W-1:0] r_first;

    always_comb
    begin
        fold_diff = {1'b0, pos_rem} - {1'b0, off_rem};
        if (fold_diff[M_W])
        begin
            r_first = fold_diff[M_W-1:0] + modulus;
        end
        else
        begin
            r_first = fold_diff[M_W-1:0];
        end
    end

    // Mirror: an index in the upper half reads 2L-1-r
    logic [M_W-1:0] mir_idx;
    logic [M_W-1:0] r_inc;

    always_comb
    begin
        if (r_reg >= M_W'(len_eff))
        begin
            mir_idx = modulus - M_W'(1) - r_reg;
        end
        else
        begin
            mir_idx = r_reg;
        end
        r_inc = r_reg + M_W'(1);
    end

    // ------------------------------------------------------------------
    // Line memory
    // ------------------------------------------------------------------
    logic [LL_W-1:0]     pos_ext;
    logic                ram_we;
    logic                ram_re;
    logic [SAMPLE_W-1:0] ram_rdata;

    assign pos_ext = LL_W'(position);
    assign ram_we  = in_fire && (command == CMD_STORE) && (pos_ext < LL_W'(LINE_MAX));
    assign ram_re  = (state_reg == S_TAPS);

    mblf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (LINE_MAX)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_ext[AW-1:0]),
        .wdata (sample),
        .re    (ram_re),
        .raddr (mir_idx[AW-1:0]),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Coefficient select for the tap being issued
    // ------------------------------------------------------------------
    logic [TS_W-1:0]          tap_sel;
    logic signed [COEF_W-1:0] coef_cur;

    always_comb
    begin
        tap_sel = TS_W'(tap_cnt_reg[TI_W-1:0]);
        if (tap_sel < TS_W'(NUM_COEFS))
        begin
            coef_cur = coef_reg[tap_sel[3:2]][tap_sel[1:0]*COEF_W +: COEF_W];
        end
        else
        begin
            coef_cur = '0;   // taps past sixteen have no coefficient
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic last_tap;
    logic out_load;

    assign last_tap = ((tap_cnt_reg + TC_W'(1)) == taps_eff);
    assign out_load = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next   = state_reg;
        r_next       = r_reg;
        tap_cnt_next = tap_cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && is_compute)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                if (fold_done)
                begin
                    r_next       = r_first;
                    tap_cnt_next = '0;
                    state_next   = (taps_eff == '0) ? S_DRAIN : S_TAPS;
                end
            end
            S_TAPS:
            begin
                tap_cnt_next = tap_cnt_reg + TC_W'(1);
                r_next       = (r_inc == modulus) ? '0 : r_inc;
                if (last_tap)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!s1_vld_reg && !s2_vld_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            tap_cnt_reg <= '0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            tap_cnt_reg <= tap_cnt_next;
            s1_vld_reg  <= ram_re;
            s2_vld_reg  <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
    end

    // ------------------------------------------------------------------
    // Multiply-accumulate: read -> product -> accumulate
    // ------------------------------------------------------------------
    logic signed [COEF_W-1:0] coef_s1_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    always_ff @(posedge clk)
    begin
        coef_s1_reg <= coef_cur;
        prod_reg    <= $signed(ram_rdata) * coef_s1_reg;
        if (in_fire && is_compute)
        begin
            acc_reg <= '0;
        end
        else if (s2_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // ------------------------------------------------------------------
    // Round half up, shift, saturate
    // ------------------------------------------------------------------
    logic signed [ACC_W:0]      rnd_sum;
    logic signed [RS_W-1:0]     rnd_q;
    logic signed [SAMPLE_W-1:0] res_value;
    logic                       res_sat;

    always_comb
    begin
        rnd_sum = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(ROUND_HALF);
        rnd_q   = $signed(rnd_sum[ACC_W:ROUND_SHIFT]);
        if (rnd_q > SAT_HI)
        begin
            res_value = SAMPLE_W'(SAMPLE_MAX);
            res_sat   = 1'b1;
        end
        else if (rnd_q < SAT_LO)
        begin
            res_value = SAMPLE_W'(SAMPLE_MIN);
            res_sat   = 1'b1;
        end
        else
        begin
            res_value = rnd_q[SAMPLE_W-1:0];
            res_sat   = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] filtered_reg;
    logic                       saturated_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            filtered_reg  <= res_value;
            saturated_reg <= res_sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;
    assign saturated = saturated_reg;

endmodule
